[hw/rtl/rect_overlap_points_defines.svh]
// Assertion macros shared by the rect_overlap_points RTL.
// Macros assume a clock named clk and an active-high reset named rst.
`ifndef RECT_OVERLAP_POINTS_DEFINES_SVH
`define RECT_OVERLAP_POINTS_DEFINES_SVH

// Same-cycle implication.
`define ROP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ROP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rop_pkg.sv]
// Types, constants and geometry helpers for rect_overlap_points.
// No dependencies.
`default_nettype none

package rop_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int CW             = 32;   // exact corner width
  localparam int NPTS           = 16;   // candidate points per item

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } rop_rect_t;

  // One item after the tests: both rectangles and the candidate mask.
  typedef struct packed {
    rop_rect_t        ra;
    rop_rect_t        rb;
    logic [NPTS-1:0]  mask;
  } rop_cand_t;

  function automatic rop_rect_t make_rect(logic [30:0] x, logic [30:0] y,
                                          logic [29:0] l, logic [29:0] h);
    rop_rect_t r;
    coord_t    x0, y0, x1, y1;
    x0 = {x[30], x};
    y0 = {y[30], y};
    x1 = x0 + {2'b00, l};
    y1 = y0 + {2'b00, h};
    r.x = {x0, x1, x1, x0};   // packed [3:0]: element 3 first
    r.y = {y1, y1, y0, y0};
    return r;
  endfunction

  function automatic logic in_box(coord_t px, coord_t py, rop_rect_t q);
    return ($signed(px) >= $signed(q.x[0])) && ($signed(px) <= $signed(q.x[1])) &&
           ($signed(py) >= $signed(q.y[0])) && ($signed(py) <= $signed(q.y[2]));
  endfunction

  // Horizontal edge i of p against vertical edge i of q.
  function automatic logic crosses(rop_rect_t p, rop_rect_t q, logic [1:0] i);
    coord_t lo, hi, e0, e1, hy, vx;
    hy = p.y[i];
    vx = q.x[i];
    case (i) inside
      2'd0, 2'd3: begin
        lo = q.y[0];
        hi = q.y[3];
      end
      default: begin
        lo = q.y[1];
        hi = q.y[2];
      end
    endcase
    case (i) inside
      2'd0, 2'd1: begin
        e0 = p.x[0];
        e1 = p.x[1];
      end
      default: begin
        e0 = p.x[3];
        e1 = p.x[2];
      end
    endcase
    return ($signed(hy) >= $signed(lo)) && ($signed(hy) <= $signed(hi)) &&
           (($signed(e0) > $signed(vx)) != ($signed(e1) > $signed(vx)));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rop_serial.sv]
// Point serializer and output register for rect_overlap_points.
// Depends on rop_pkg and rect_overlap_points_defines.svh.
`default_nettype none
`include "rect_overlap_points_defines.svh"

module rop_serial
  import rop_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               ld_valid,
  output logic                    ld_ready,
  input  wire rop_cand_t          ld_cand,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [CW-1:0]    pt_x,
  output logic signed [CW-1:0]    pt_y,
  output logic                    no_points,
  output logic                    last_point
);

  localparam int WB = (COORD_BITS < CW) ? COORD_BITS : CW;

  logic            ser_v;
  rop_rect_t       ra, rb;
  logic [NPTS-1:0] mask;

  logic [3:0]      idx;
  logic [NPTS-1:0] rest;
  logic            ser_last, empty, out_load;
  coord_t          px, py;
  logic [CW-1:0]   wx, wy;

  // lowest pending candidate goes first
  always_comb begin
    idx = '0;
    for (int b = NPTS - 1; b >= 0; b--) begin
      if (mask[b]) idx = 4'(b);
    end
  end

  assign rest     = mask & ~(NPTS'(1) << idx);
  assign empty    = (mask == '0);
  assign ser_last = empty || (rest == '0);
  assign out_load = ser_v && (!out_valid || out_ready);
  assign ld_ready = !ser_v || (out_load && ser_last);

  always_comb begin
    case (idx[3:2])
      2'd0: begin
        px = ra.x[idx[1:0]];
        py = ra.y[idx[1:0]];
      end
      2'd1: begin
        px = rb.x[idx[1:0]];
        py = rb.y[idx[1:0]];
      end
      2'd2: begin
        px = rb.x[idx[1:0]];
        py = ra.y[idx[1:0]];
      end
      default: begin
        px = ra.x[idx[1:0]];
        py = rb.y[idx[1:0]];
      end
    endcase
  end

  // two's complement wrap to the coordinate width
  always_comb begin
    for (int b = 0; b < CW; b++) begin
      wx[b] = (b < WB) ? px[b] : px[WB-1];
      wy[b] = (b < WB) ? py[b] : py[WB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld_valid && ld_ready) begin
        ser_v <= 1'b1;
      end else if (out_load && ser_last) begin
        ser_v <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) begin
      ra   <= ld_cand.ra;
      rb   <= ld_cand.rb;
      mask <= ld_cand.mask;
    end else if (out_load) begin
      mask <= rest;
    end
    if (out_load) begin
      pt_x       <= empty ? '0 : $signed(wx);
      pt_y       <= empty ? '0 : $signed(wy);
      no_points  <= empty;
      last_point <= ser_last;
    end
  end

  `ROP_ASSERT_NOW(a_empty_fmt, out_valid && no_points,
                  last_point && pt_x == '0 && pt_y == '0,
                  "empty item must be a single zero result")
  `ROP_ASSERT_NEXT(a_no_drop, out_load && !ser_last, ser_v,
                   "item left the serializer early")
  `ROP_ASSERT_NEXT(a_mask_step, out_load && !ser_last && !(ld_valid && ld_ready),
                   $countones(mask) == $past($countones(mask)) - 1,
                   "serializer must retire one point per result")

endmodule

`default_nettype wire

[hw/rtl/rect_overlap_points.sv]
// Top level of rect_overlap_points: input register, corner stage, test stage.
// Depends on rop_pkg, rop_serial and rect_overlap_points_defines.svh.
//
//   channel | signals                                  | dir | item
//   --------+------------------------------------------+-----+-------------------------
//   in      | in_valid/in_ready, rect_a_*, rect_b_*    | in  | one rectangle pair
//   out     | out_valid/out_ready, pt_x, pt_y, flags   | out | one overlap point
//
// An accepted item passes the input register, the corner-sum register, the serializer
// (loaded with the inside/crossing compares), then the output register.
// The serializer emits one point per cycle unless out_ready stalls it, so an item with n
// points gives max(n,1) results (1 to 16); that single result port sets the rate.
// The next item loads with the previous item's last point: items run back to back.
// Synchronous reset empties every stage; out_ready low stalls what cannot move.
`default_nettype none
`include "rect_overlap_points_defines.svh"

module rect_overlap_points
  import rop_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [30:0] rect_a_x,
  input  wire logic signed [30:0] rect_a_y,
  input  wire logic        [29:0] rect_a_len,
  input  wire logic        [29:0] rect_a_hgt,
  input  wire logic signed [30:0] rect_b_x,
  input  wire logic signed [30:0] rect_b_y,
  input  wire logic        [29:0] rect_b_len,
  input  wire logic        [29:0] rect_b_hgt,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [CW-1:0]    pt_x,
  output logic signed [CW-1:0]    pt_y,
  output logic                    no_points,
  output logic                    last_point
);

  // stage 0: raw input register
  logic        v0;
  logic [30:0] ax0, ay0, bx0, by0;
  logic [29:0] al0, ah0, bl0, bh0;

  // stage 1: corner coordinates
  logic      v1;
  rop_rect_t ra1, rb1;

  logic      adv0, adv1, ready1, ld_ready;
  rop_cand_t cand;

  assign ready1   = !v1 || ld_ready;
  assign adv1     = v1 && ld_ready;
  assign adv0     = v0 && ready1;
  assign in_ready = !v0 || ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        v0 <= 1'b1;
      end else if (adv0) begin
        v0 <= 1'b0;
      end
      if (adv0) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax0 <= rect_a_x;
      ay0 <= rect_a_y;
      al0 <= rect_a_len;
      ah0 <= rect_a_hgt;
      bx0 <= rect_b_x;
      by0 <= rect_b_y;
      bl0 <= rect_b_len;
      bh0 <= rect_b_hgt;
    end
    if (adv0) begin
      ra1 <= make_rect(ax0, ay0, al0, ah0);
      rb1 <= make_rect(bx0, by0, bl0, bh0);
    end
  end

  // Candidate order: A corners in B, B corners in A, A horizontals across
  // B verticals, B horizontals across A verticals.
  always_comb begin
    cand.ra = ra1;
    cand.rb = rb1;
    for (int i = 0; i < 4; i++) begin
      cand.mask[i]      = in_box(ra1.x[i], ra1.y[i], rb1);
      cand.mask[4 + i]  = in_box(rb1.x[i], rb1.y[i], ra1);
      cand.mask[8 + i]  = crosses(ra1, rb1, 2'(i));
      cand.mask[12 + i] = crosses(rb1, ra1, 2'(i));
    end
  end

  rop_serial #(
    .COORD_BITS(COORD_BITS)
  ) u_serial (
    .clk        (clk),
    .rst        (rst),
    .ld_valid   (v1),
    .ld_ready   (ld_ready),
    .ld_cand    (cand),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .no_points  (no_points),
    .last_point (last_point)
  );

  `ROP_ASSERT_NEXT(a_take_fills, in_valid && in_ready, v0, "accepted item not captured")
  `ROP_ASSERT_NEXT(a_hold_s0, v0 && !adv0, v0 && $stable(ax0) && $stable(bh0),
                   "stage 0 lost a stalled item")
  `ROP_ASSERT_NEXT(a_hold_s1, v1 && !adv1, v1 && $stable(ra1) && $stable(rb1),
                   "stage 1 lost a stalled item")

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking bench for rect_overlap_points: random and directed rectangle pairs.
// Holds its own overlap-point predictor and a point queue; needs rop_pkg and the RTL.

typedef struct packed {
  logic signed [30:0] a_x;
  logic signed [30:0] a_y;
  logic        [29:0] a_len;
  logic        [29:0] a_hgt;
  logic signed [30:0] b_x;
  logic signed [30:0] b_y;
  logic        [29:0] b_len;
  logic        [29:0] b_hgt;
} rect_pair_t;

typedef struct {
  rop_pkg::coord_t x;
  rop_pkg::coord_t y;
  logic            none;
  logic            last;
} overlap_pt_t;

// Exact bounds of one rectangle.
typedef struct {
  longint x0;
  longint x1;
  longint y0;
  longint y1;
} box_t;

class outline_board;
  overlap_pt_t pending[$];   // points still owed by the block, oldest first
  overlap_pt_t item_pts[$];  // points of the pair being worked out
  int          mismatches;

  function new();
    mismatches = 0;
  endfunction

  task report(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // Two's complement wrap to the coordinate width, then the low 32 bits.
  function rop_pkg::coord_t wrap(longint v);
    longint w;
    w = (v <<< (64 - rop_pkg::COORD_BITS_DEF)) >>> (64 - rop_pkg::COORD_BITS_DEF);
    return w[31:0];
  endfunction

  function box_t to_box(logic [30:0] x, logic [30:0] y, logic [29:0] l, logic [29:0] h);
    box_t r;
    r.x0 = longint'($signed(x));
    r.y0 = longint'($signed(y));
    r.x1 = r.x0 + longint'(l);
    r.y1 = r.y0 + longint'(h);
    return r;
  endfunction

  function void note(longint x, longint y);
    overlap_pt_t t;
    t.x    = wrap(x);
    t.y    = wrap(y);
    t.none = 1'b0;
    t.last = 1'b0;
    item_pts.push_back(t);
  endfunction

  // Corners of p inside q, corner order (x0,y0) (x1,y0) (x1,y1) (x0,y1).
  function void corners_in(box_t p, box_t q);
    longint cx[4];
    longint cy[4];
    cx = '{p.x0, p.x1, p.x1, p.x0};
    cy = '{p.y0, p.y0, p.y1, p.y1};
    for (int i = 0; i < 4; i++)
      if (cx[i] >= q.x0 && cx[i] <= q.x1 && cy[i] >= q.y0 && cy[i] <= q.y1)
        note(cx[i], cy[i]);
  endfunction

  // Horizontal edges of p (bottom twice, top twice) against the vertical
  // edges of q (left, right, right, left).
  function void crossings(box_t p, box_t q);
    longint hy;
    longint vx;
    for (int i = 0; i < 4; i++) begin
      hy = (i < 2) ? p.y0 : p.y1;
      vx = (i == 0 || i == 3) ? q.x0 : q.x1;
      if (hy >= q.y0 && hy <= q.y1 && ((p.x0 > vx) != (p.x1 > vx)))
        note(vx, hy);
    end
  endfunction

  function void take_pair(rect_pair_t p);
    box_t        a;
    box_t        b;
    overlap_pt_t empty_pt;
    a = to_box(p.a_x, p.a_y, p.a_len, p.a_hgt);
    b = to_box(p.b_x, p.b_y, p.b_len, p.b_hgt);
    item_pts.delete();
    corners_in(a, b);
    corners_in(b, a);
    crossings(a, b);
    crossings(b, a);
    if (item_pts.size() == 0) begin
      empty_pt.x    = '0;
      empty_pt.y    = '0;
      empty_pt.none = 1'b1;
      empty_pt.last = 1'b1;
      item_pts.push_back(empty_pt);
    end else begin
      item_pts[item_pts.size() - 1].last = 1'b1;
    end
    foreach (item_pts[i]) pending.push_back(item_pts[i]);
  endfunction

  task check_point(rop_pkg::coord_t x, rop_pkg::coord_t y, logic none, logic last);
    overlap_pt_t want;
    if (pending.size() == 0) begin
      report($sformatf("point (%0d,%0d) with none pending", $signed(x), $signed(y)));
      return;
    end
    want = pending.pop_front();
    if (x !== want.x)
      report($sformatf("pt_x %0d, expected %0d", $signed(x), $signed(want.x)));
    if (y !== want.y)
      report($sformatf("pt_y %0d, expected %0d", $signed(y), $signed(want.y)));
    if (none !== want.none)
      report($sformatf("no_points %b, expected %b", none, want.none));
    if (last !== want.last)
      report($sformatf("last_point %b, expected %b", last, want.last));
  endtask
endclass

module tb;
  import rop_pkg::*;

  // Output-side stall patterns, picked per stretch of cycles.
  typedef enum int {SINK_OPEN, SINK_HALF, SINK_MOSTLY, SINK_SPARSE} sink_mode_e;

  localparam int RANDOM_PAIRS = 450;
  localparam int HOLD_CYCLES  = 400;   // long output stall to back the block up
  localparam int HOLD_AFTER   = 120;   // pairs taken before that stall starts

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [30:0] rect_a_x = '0;
  logic signed [30:0] rect_a_y = '0;
  logic        [29:0] rect_a_len = '0;
  logic        [29:0] rect_a_hgt = '0;
  logic signed [30:0] rect_b_x = '0;
  logic signed [30:0] rect_b_y = '0;
  logic        [29:0] rect_b_len = '0;
  logic        [29:0] rect_b_hgt = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  coord_t             pt_x;
  coord_t             pt_y;
  logic               no_points;
  logic               last_point;

  outline_board board;
  int           pairs_taken = 0;

  rect_overlap_points u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rect_a_x   (rect_a_x),
    .rect_a_y   (rect_a_y),
    .rect_a_len (rect_a_len),
    .rect_a_hgt (rect_a_hgt),
    .rect_b_x   (rect_b_x),
    .rect_b_y   (rect_b_y),
    .rect_b_len (rect_b_len),
    .rect_b_hgt (rect_b_hgt),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .no_points  (no_points),
    .last_point (last_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshake monitor. It runs right at the edge, before this edge's
  // nonblocking updates land, so it sees exactly what the block sampled.
  // The predictor runs on accept; every accepted point pops one expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.take_pair({rect_a_x, rect_a_y, rect_a_len, rect_a_hgt,
                         rect_b_x, rect_b_y, rect_b_len, rect_b_hgt});
        pairs_taken++;
      end
      if (out_valid && out_ready) board.check_point(pt_x, pt_y, no_points, last_point);
    end
  end

  // Present one pair and hold it steady until it is taken. Returns at the
  // accepting edge with in_valid still high, so a following call does not
  // toggle valid within one step.
  task automatic send_pair(input rect_pair_t p);
    rect_a_x   <= p.a_x;
    rect_a_y   <= p.a_y;
    rect_a_len <= p.a_len;
    rect_a_hgt <= p.a_hgt;
    rect_b_x   <= p.b_x;
    rect_b_y   <= p.b_y;
    rect_b_len <= p.b_len;
    rect_b_hgt <= p.b_hgt;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic rect_pair_t pair_of(int ax, int ay, int al, int ah,
                                         int bx, int by, int bl, int bh);
    rect_pair_t p;
    p.a_x   = 31'(ax);
    p.a_y   = 31'(ay);
    p.a_len = 30'(al);
    p.a_hgt = 30'(ah);
    p.b_x   = 31'(bx);
    p.b_y   = 31'(by);
    p.b_len = 30'(bl);
    p.b_hgt = 30'(bh);
    return p;
  endfunction

  function automatic int jitter(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Mostly pairs placed near each other at a random scale so that corners,
  // crossings and shared edges all show up; a fifth are raw full-range
  // noise, which also toggles every input bit.
  function automatic rect_pair_t random_pair();
    rect_pair_t p;
    int         r;
    int         cx;
    int         cy;
    if ($urandom_range(0, 9) < 2) begin
      p.a_x   = 31'($urandom);
      p.a_y   = 31'($urandom);
      p.a_len = 30'($urandom);
      p.a_hgt = 30'($urandom);
      p.b_x   = 31'($urandom);
      p.b_y   = 31'($urandom);
      p.b_len = 30'($urandom);
      p.b_hgt = 30'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       r = 4;      // tiny: lots of equal coordinates
        1:       r = 64;
        2:       r = 4096;
        default: r = 1 << 20;
      endcase
      cx = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      cy = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      p.a_x   = 31'(cx + jitter(r));
      p.a_y   = 31'(cy + jitter(r));
      p.a_len = 30'($urandom_range(0, 2 * r));
      p.a_hgt = 30'($urandom_range(0, 2 * r));
      p.b_x   = 31'(cx + jitter(r));
      p.b_y   = 31'(cy + jitter(r));
      p.b_len = 30'($urandom_range(0, 2 * r));
      p.b_hgt = 30'($urandom_range(0, 2 * r));
    end
    return p;
  endfunction

  // Output side: stretches of random stall patterns, including fully open
  // ones, plus one long hold-off once traffic is flowing so that the
  // pipeline fills and in_ready has to drop.
  initial begin : sink
    sink_mode_e mode;
    int         span;
    bit         held;
    mode = SINK_OPEN;
    span = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && pairs_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
          SINK_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus: reset, directed corner cases, then bursty random traffic.
  initial begin : source
    int sent;
    int burst;
    int gap;
    int drain;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // disjoint, then disjoint in y only: the empty result
    send_pair(pair_of(0, 0, 10, 10, 100, 100, 10, 10));
    send_pair(pair_of(0, 0, 10, 10, 0, 50, 10, 10));
    // identical rectangles: twelve points, duplicates kept
    send_pair(pair_of(0, 0, 256, 256, 0, 0, 256, 256));
    // one nested inside the other, both ways
    send_pair(pair_of(10, 10, 5, 5, 0, 0, 100, 100));
    send_pair(pair_of(0, 0, 100, 100, 10, 10, 5, 5));
    // plus shape: crossings only
    send_pair(pair_of(0, 40, 100, 20, 40, 0, 20, 100));
    send_pair(pair_of(0, 0, 100, 100, -50, 40, 200, 20));
    // ordinary corner overlap, negative coordinates too
    send_pair(pair_of(0, 0, 50, 50, 25, 25, 50, 50));
    send_pair(pair_of(-300, -300, 200, 200, -200, -250, 300, 100));
    // shared edge, shared corner
    send_pair(pair_of(0, 0, 10, 10, 10, 0, 10, 10));
    send_pair(pair_of(0, 0, 10, 10, 10, 10, 5, 5));
    // zero extent: coincident points, point inside, segments through a box
    send_pair(pair_of(5, 5, 0, 0, 5, 5, 0, 0));
    send_pair(pair_of(5, 5, 0, 0, 0, 0, 10, 10));
    send_pair(pair_of(5, -5, 0, 20, 0, 0, 10, 10));
    send_pair(pair_of(-5, 5, 20, 0, 0, 0, 10, 10));
    // field extremes: lowest origin, highest origin, largest extents
    send_pair(pair_of(-1073741824, -1073741824, 1073741823, 1073741823,
                      -1073741824, -1073741824, 1073741823, 1073741823));
    send_pair(pair_of(1073741823, 1073741823, 1073741823, 1073741823,
                      1073741823, 1073741823, 1073741823, 1073741823));
    send_pair(pair_of(-1073741824, -1073741824, 1073741823, 1073741823,
                      1073741823, 1073741823, 0, 0));
    send_pair(pair_of(-1073741824, -1073741824, 1073741823, 1073741823,
                      -1073741824, -1073741824, 0, 0));
    send_pair(pair_of(-1, -1, 1073741823, 1073741823, -1, -1, 1073741823, 0));
    send_pair(pair_of(1073741823, -1073741824, 0, 1073741823,
                      -1073741824, 0, 1073741823, 0));

    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_pair(random_pair());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) pause_input(gap);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain, then wait on to catch stray points.
    drain = 0;
    while (board.pending.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (board.pending.size() != 0)
      board.report($sformatf("%0d points never arrived", board.pending.size()));

    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every pair at sixteen points
  // behind the sparsest stall pattern, plus gaps and the long hold-off).
  initial begin : watchdog
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rop_pkg.sv
hw/rtl/rop_serial.sv
hw/rtl/rect_overlap_points.sv
verif/tb.sv
